[rtl/spa_pkg.sv]
// Package for the sparse polynomial adder.
// Holds list capacity, field widths, operation codes and sequencer states.
// Has no dependencies.
`default_nettype none

package spa_pkg;

  localparam int MAX_TERMS = 256;
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 16;
  localparam int EXPO_W    = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int WORD_W    = COEF_W + EXPO_W;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] term_word_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD_A = 2'd1,
    OP_LOAD_B = 2'd2,
    OP_FETCH  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

endpackage

`default_nettype wire

[rtl/sparse_polynomial_add.sv]
// Sparse polynomial adder by sorted merge of two term lists held in memories.
// Depends on spa_pkg for widths, operation codes and sequencer states.
//
// Usage: each input beat carries an operation and one term. A clear beat empties
// both lists and rewinds the merge. A load beat appends the term to list A or B;
// a load into a full list is dropped and sets the sticky overflow flag. A fetch
// beat returns one output beat with the next term of A+B, or valid_term low when
// both lists are used up.
// Clear and load beats give no output beat. A fetch stays in the merge state while
// it skips every head term or head pair whose coefficient sum is zero, since the
// one registered read port of each list memory feeds the single shared compare
// and add unit. While a fetch is in
// progress in_stall is high. The result sits in an output register, so loads and
// clears are taken while it waits; a later fetch waits in the merge state until
// the output register is free, holding its place in the lists.
// Reset empties both lists, rewinds the merge and clears the overflow flag and
// out_valid. List memory contents are not cleared, and no entry beyond a list's
// fill count is ever read into a result.
`default_nettype none

module sparse_polynomial_add
  import spa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_op,
  input  wire logic signed [COEF_W-1:0] in_term_coef,
  input  wire logic [EXPO_W-1:0]        in_term_expo,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [SUM_W-1:0]       out_sum_coef,
  output logic [EXPO_W-1:0]             out_sum_expo,
  output logic                          out_valid_term,
  output logic                          out_overflow
);

  term_word_t mem_a [MAX_TERMS];
  term_word_t mem_b [MAX_TERMS];
  term_word_t rd_a_r;
  term_word_t rd_b_r;

  state_t state_r, state_nxt;
  cnt_t   count_a_r, count_a_nxt;
  cnt_t   count_b_r, count_b_nxt;
  cnt_t   ptr_a_r, ptr_a_nxt;
  cnt_t   ptr_b_r, ptr_b_nxt;
  logic   overflow_r, overflow_nxt;
  logic   we_a, we_b;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]  sum_coef_r, sum_coef_nxt;
  logic [EXPO_W-1:0]        sum_expo_r, sum_expo_nxt;
  logic                     valid_term_r, valid_term_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic                     has_a, has_b;
  logic [EXPO_W-1:0]        expo_a, expo_b;
  logic signed [COEF_W-1:0] coef_a, coef_b;
  logic                     take_a, take_b;
  logic signed [SUM_W-1:0]  add_x, add_y, add_sum;
  op_t                      op;

  assign op      = op_t'(in_op);
  assign expo_a  = rd_a_r[WORD_W-1:COEF_W];
  assign expo_b  = rd_b_r[WORD_W-1:COEF_W];
  assign coef_a  = rd_a_r[COEF_W-1:0];
  assign coef_b  = rd_b_r[COEF_W-1:0];
  assign has_a   = ptr_a_r < count_a_r;
  assign has_b   = ptr_b_r < count_b_r;

  // On a tie in exponent both heads are consumed and added.
  assign take_a  = has_a && (!has_b || (expo_a >= expo_b));
  assign take_b  = has_b && (!has_a || (expo_b >= expo_a));
  assign add_x   = take_a ? SUM_W'(coef_a) : SUM_W'(coef_b);
  assign add_y   = (take_a && take_b) ? SUM_W'(coef_b) : '0;
  assign add_sum = add_x + add_y;

  always_comb begin
    state_nxt      = state_r;
    count_a_nxt    = count_a_r;
    count_b_nxt    = count_b_r;
    ptr_a_nxt      = ptr_a_r;
    ptr_b_nxt      = ptr_b_r;
    overflow_nxt   = overflow_r;
    we_a           = 1'b0;
    we_b           = 1'b0;
    in_stall       = 1'b1;
    out_valid_nxt  = out_valid_r && out_stall;
    sum_coef_nxt   = sum_coef_r;
    sum_expo_nxt   = sum_expo_r;
    valid_term_nxt = valid_term_r;
    out_ovf_nxt    = out_ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (op)
            OP_CLEAR: begin
              count_a_nxt = '0;
              count_b_nxt = '0;
              ptr_a_nxt   = '0;
              ptr_b_nxt   = '0;
            end
            OP_LOAD_A: begin
              if (count_a_r == CNT_W'(MAX_TERMS)) begin
                overflow_nxt = 1'b1;
              end else begin
                we_a        = 1'b1;
                count_a_nxt = count_a_r + 1'b1;
              end
            end
            OP_LOAD_B: begin
              if (count_b_r == CNT_W'(MAX_TERMS)) begin
                overflow_nxt = 1'b1;
              end else begin
                we_b        = 1'b1;
                count_b_nxt = count_b_r + 1'b1;
              end
            end
            OP_FETCH: begin
              state_nxt = ST_MERGE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (!out_valid_r || !out_stall) begin
          if (!has_a && !has_b) begin
            out_valid_nxt  = 1'b1;
            sum_coef_nxt   = '0;
            sum_expo_nxt   = '0;
            valid_term_nxt = 1'b0;
            out_ovf_nxt    = overflow_r;
            state_nxt      = ST_IDLE;
          end else begin
            if (take_a) begin
              ptr_a_nxt = ptr_a_r + 1'b1;
            end
            if (take_b) begin
              ptr_b_nxt = ptr_b_r + 1'b1;
            end
            if (add_sum != '0) begin
              out_valid_nxt  = 1'b1;
              sum_coef_nxt   = add_sum;
              sum_expo_nxt   = take_a ? expo_a : expo_b;
              valid_term_nxt = 1'b1;
              out_ovf_nxt    = overflow_r;
              state_nxt      = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ptr_a_r     <= '0;
      ptr_b_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ptr_a_r     <= ptr_a_nxt;
      ptr_b_r     <= ptr_b_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_coef_r   <= sum_coef_nxt;
    sum_expo_r   <= sum_expo_nxt;
    valid_term_r <= valid_term_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  // The read address follows the next pointer, so the registered head matches the pointer register.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[count_a_r[ADDR_W-1:0]] <= {in_term_expo, in_term_coef};
    end
    rd_a_r <= mem_a[ptr_a_nxt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[count_b_r[ADDR_W-1:0]] <= {in_term_expo, in_term_coef};
    end
    rd_b_r <= mem_b[ptr_b_nxt[ADDR_W-1:0]];
  end

  assign out_valid      = out_valid_r;
  assign out_sum_coef   = sum_coef_r;
  assign out_sum_expo   = sum_expo_r;
  assign out_valid_term = valid_term_r;
  assign out_overflow   = out_ovf_r;

`ifndef SYNTHESIS
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_a_r <= count_a_r) && (ptr_b_r <= count_b_r))
    else $error("merge pointer ran past its list fill count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CNT_W'(MAX_TERMS)) && (count_b_r <= CNT_W'(MAX_TERMS)))
    else $error("list fill count exceeds capacity");

  a_nonzero_term: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && valid_term_r) |-> (sum_coef_r != '0))
    else $error("valid sum term carries a zero coefficient");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag dropped without reset");

  a_merge_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> in_stall)
    else $error("input taken during a fetch");
`endif

endmodule

`default_nettype wire

[bench/sparse_polynomial_add_test.sv]
`timescale 1ns / 1ps
// Testbench for the sparse polynomial adder: loads sorted lists and noise beats,
// fetches the merged sum and checks every output beat against a merge predictor.
// Depends on spa_pkg and sparse_polynomial_add.

module sparse_polynomial_add_test
  import spa_pkg::*;
;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic signed [SUM_W-1:0] coef;
    logic [EXPO_W-1:0]       expo;
    logic                    valid;
    logic                    ovf;
  } sum_term_t;

  class merged_term_checker;
    logic signed [COEF_W-1:0] coefs [2][MAX_TERMS];
    logic [EXPO_W-1:0]        expos [2][MAX_TERMS];
    int fill [2];
    int head [2];
    bit dropped;
    sum_term_t expected_terms [$];
    int errors;
    int terms_seen;
    int empty_seen;
    int drops;

    function void take_beat(op_t op, logic signed [COEF_W-1:0] coef,
                            logic [EXPO_W-1:0] expo);
      int side;
      int total;
      logic [EXPO_W-1:0] e;
      bit has_a;
      bit has_b;
      sum_term_t t;
      case (op)
        OP_CLEAR: begin
          fill = '{0, 0};
          head = '{0, 0};
        end
        OP_LOAD_A, OP_LOAD_B: begin
          side = (op == OP_LOAD_B) ? 1 : 0;
          if (fill[side] >= MAX_TERMS) begin
            dropped = 1'b1;
            drops++;
          end else begin
            coefs[side][fill[side]] = coef;
            expos[side][fill[side]] = expo;
            fill[side]++;
          end
        end
        default: begin
          total = 0;
          e = '0;
          do begin
            has_a = head[0] < fill[0];
            has_b = head[1] < fill[1];
            if (!has_a && !has_b) break;
            if (has_a && has_b && expos[0][head[0]] == expos[1][head[1]]) begin
              total = coefs[0][head[0]] + coefs[1][head[1]];
              e = expos[0][head[0]];
              head[0]++;
              head[1]++;
            end else if (has_a && (!has_b || expos[0][head[0]] > expos[1][head[1]])) begin
              total = coefs[0][head[0]];
              e = expos[0][head[0]];
              head[0]++;
            end else begin
              total = coefs[1][head[1]];
              e = expos[1][head[1]];
              head[1]++;
            end
          end while (total == 0);
          t.coef = total[SUM_W-1:0];
          t.expo = (total != 0) ? e : '0;
          t.valid = (total != 0);
          t.ovf = dropped;
          expected_terms.push_back(t);
        end
      endcase
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_term(logic signed [SUM_W-1:0] coef, logic [EXPO_W-1:0] expo,
                             logic valid, logic ovf);
      sum_term_t t;
      if (expected_terms.size() == 0) begin
        $error("output beat with no fetch waiting: coef %0d expo %0d", coef, expo);
        errors++;
        return;
      end
      t = expected_terms.pop_front();
      compare_field("sum_coef", 32'(t.coef), 32'(coef));
      compare_field("sum_expo", 32'(t.expo), 32'(expo));
      compare_field("valid_term", 32'(t.valid), 32'(valid));
      compare_field("overflow", 32'(t.ovf), 32'(ovf));
      if (t.valid) terms_seen++;
      else empty_seen++;
    endfunction

    function int pending();
      return expected_terms.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_CLEAR;
  logic signed [COEF_W-1:0] in_term_coef = '0;
  logic [EXPO_W-1:0] in_term_expo = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SUM_W-1:0] out_sum_coef;
  logic [EXPO_W-1:0] out_sum_expo;
  logic out_valid_term;
  logic out_overflow;

  merged_term_checker sums = new();
  int beats_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  sparse_polynomial_add dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_term_coef(in_term_coef),
    .in_term_expo(in_term_expo),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sum_coef(out_sum_coef),
    .out_sum_expo(out_sum_expo),
    .out_valid_term(out_valid_term),
    .out_overflow(out_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sums.check_term(out_sum_coef, out_sum_expo, out_valid_term, out_overflow);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2);
      stall_left = $urandom_range(200, 20);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      default: out_stall <= ($urandom_range(3) != 0);
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sparse_polynomial_add: mismatch");
    $finish;
  end

  function automatic logic signed [COEF_W-1:0] random_coef();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(op_t op, logic signed [COEF_W-1:0] coef,
                           logic [EXPO_W-1:0] expo);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_term_coef <= coef;
    in_term_expo <= expo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sums.take_beat(op, coef, expo);
    beats_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sums.pending() != 0) @(posedge clk);
  endtask

  task automatic run_merge_case();
    int slots;
    int e;
    int step;
    int kind;
    int fetches;
    logic signed [COEF_W-1:0] ca;
    logic signed [COEF_W-1:0] cb;
    slots = $urandom_range(12, 0);
    send_beat(OP_CLEAR, COEF_W'($urandom), EXPO_W'($urandom));
    e = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535, 20000);
    for (int i = 0; i < slots && e >= 0; i++) begin
      kind = $urandom_range(2);
      ca = random_coef();
      cb = ($urandom_range(2) == 0) ? -ca : random_coef();
      if (kind != 1) send_beat(OP_LOAD_A, ca, e[EXPO_W-1:0]);
      if (kind != 0) send_beat(OP_LOAD_B, cb, e[EXPO_W-1:0]);
      step = $urandom_range(5000, 1);
      e = (e > 0 && e < step) ? 0 : e - step;
    end
    fetches = $urandom_range(2 * slots + 2, slots);
    repeat (fetches) send_beat(OP_FETCH, COEF_W'($urandom), EXPO_W'($urandom));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(10, 1)) begin
      send_beat(op_t'($urandom_range(3)), COEF_W'($urandom), EXPO_W'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(OP_FETCH, 16'sh0000, 16'h0000);
    send_beat(OP_LOAD_A, 16'sh7FFF, 16'hFFFF);
    send_beat(OP_LOAD_A, 16'sh8000, 16'd40000);
    send_beat(OP_LOAD_A, 16'sh0000, 16'd30000);
    send_beat(OP_LOAD_A, 16'sd5, 16'd100);
    send_beat(OP_LOAD_A, -16'sd7, 16'h0000);
    send_beat(OP_LOAD_B, 16'sh8000, 16'hFFFF);
    send_beat(OP_LOAD_B, 16'sh8000, 16'd40000);
    send_beat(OP_LOAD_B, -16'sd5, 16'd100);
    send_beat(OP_LOAD_B, 16'sd1, 16'd50);
    repeat (6) send_beat(OP_FETCH, 16'shFFFF, 16'hFFFF);
    send_beat(OP_LOAD_A, 16'sh7FFF, 16'd7);
    send_beat(OP_LOAD_B, 16'sh7FFF, 16'd7);
    send_beat(OP_FETCH, 16'sh0000, 16'h0000);
    send_beat(OP_LOAD_A, 16'sd1, 16'd10);
    send_beat(OP_LOAD_A, 16'sd2, 16'd20);
    send_beat(OP_LOAD_B, 16'sd4, 16'd20);
    repeat (3) send_beat(OP_FETCH, 16'sh0000, 16'h0000);
    send_beat(OP_CLEAR, 16'shFFFF, 16'hFFFF);
    send_beat(OP_FETCH, 16'sh0000, 16'h0000);

    while (beats_sent < 200) begin
      if ($urandom_range(7) == 0) run_noise();
      else run_merge_case();
      if ($urandom_range(5) == 0) wait_for_results();
    end
    wait_for_results();

    send_beat(OP_CLEAR, 16'sh0000, 16'h0000);
    for (int i = 0; i < MAX_TERMS + 2; i++) begin
      send_beat(OP_LOAD_A, random_coef(), 16'(65535 - i * 250));
    end
    send_beat(OP_LOAD_B, random_coef(), 16'(65535 - 7 * 250));
    send_beat(OP_LOAD_B, random_coef(), 16'h0000);
    repeat (MAX_TERMS + 4) send_beat(OP_FETCH, COEF_W'($urandom), EXPO_W'($urandom));
    send_beat(OP_CLEAR, COEF_W'($urandom), EXPO_W'($urandom));
    send_beat(OP_LOAD_B, 16'sd3, 16'd9);
    repeat (2) send_beat(OP_FETCH, COEF_W'($urandom), EXPO_W'($urandom));

    wait_for_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d input beats: directed extremes, random sorted merges, noise",
             beats_sent);
    $display("and a full list A; %0d sum terms, %0d exhausted answers, %0d dropped loads.",
             sums.terms_seen, sums.empty_seen, sums.drops);
    if (sums.errors == 0 && sums.pending() == 0) begin
      $display("sparse_polynomial_add: match");
    end else begin
      $display("sparse_polynomial_add: mismatch");
    end
    $finish;
  end

endmodule
